>>> hdl/mefe_pkg.sv
// Package for the mesh element face extractor: payload structs, element kinds,
// face tables and the canonical reordering function. No dependencies.
package mefe_pkg;

   localparam int NodeWidth  = 31;
   localparam int OwnerWidth = 32;
   localparam int SidWidth   = 16;
   localparam int NumNodes   = 8;
   localparam int NumRows    = 22;
   localparam int RowWidth   = $clog2(NumRows);
   localparam int IdxWidth   = 3;

   // element type codes as they arrive on opcode
   localparam logic [3:0] OP_LINE    = 4'd1;
   localparam logic [3:0] OP_TRI     = 4'd2;
   localparam logic [3:0] OP_QUAD    = 4'd3;
   localparam logic [3:0] OP_TET     = 4'd4;
   localparam logic [3:0] OP_HEX     = 4'd5;
   localparam logic [3:0] OP_PRISM   = 4'd6;
   localparam logic [3:0] OP_PYRAMID = 4'd7;
   localparam logic [3:0] OP_POINT   = 4'd15;

   typedef struct packed {
      logic [3:0]             opcode;
      logic [NodeWidth-1:0]   node_a;
      logic [NodeWidth-1:0]   node_b;
      logic [NodeWidth-1:0]   node_c;
      logic [NodeWidth-1:0]   node_d;
      logic [NodeWidth-1:0]   node_e;
      logic [NodeWidth-1:0]   node_f;
      logic [NodeWidth-1:0]   node_g;
      logic [NodeWidth-1:0]   node_h;
      logic [SidWidth-1:0]    surface_id;
   } req_type;

   typedef struct packed {
      logic                          is_quad;
      logic [NodeWidth-1:0]          corner_a;
      logic [NodeWidth-1:0]          corner_b;
      logic [NodeWidth-1:0]          corner_c;
      logic [NodeWidth-1:0]          corner_d;
      logic signed [OwnerWidth-1:0]  owner_cell;
      logic                          orient_left;
      logic                          bad_type;
      logic                          last_face;
   } rsp_type;

   // what an accepted element turns into
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_TRI,
      KIND_QUAD,
      KIND_TET,
      KIND_HEX,
      KIND_PRISM,
      KIND_PYR,
      KIND_BAD
   } kind_type;

   // one face: quad flag and the node slot of each corner
   typedef struct packed {
      logic             quad;
      logic [0:3][2:0]  pick;
   } face_row_type;

   // corner order after canonical reordering, plus orientation flag
   typedef struct packed {
      logic [0:3][1:0]  sel;
      logic             left;
   } canon_type;

   localparam face_row_type FACE_ROWS [NumRows] = '{
      // tetrahedron
      '{1'b0, '{3'd0, 3'd2, 3'd1, 3'd0}}, '{1'b0, '{3'd0, 3'd3, 3'd2, 3'd0}},
      '{1'b0, '{3'd0, 3'd1, 3'd3, 3'd0}}, '{1'b0, '{3'd1, 3'd2, 3'd3, 3'd0}},
      // hexahedron
      '{1'b1, '{3'd0, 3'd3, 3'd2, 3'd1}}, '{1'b1, '{3'd0, 3'd1, 3'd5, 3'd4}},
      '{1'b1, '{3'd0, 3'd4, 3'd7, 3'd3}}, '{1'b1, '{3'd6, 3'd2, 3'd3, 3'd7}},
      '{1'b1, '{3'd6, 3'd7, 3'd4, 3'd5}}, '{1'b1, '{3'd6, 3'd5, 3'd1, 3'd2}},
      // prism
      '{1'b0, '{3'd0, 3'd2, 3'd1, 3'd0}}, '{1'b0, '{3'd3, 3'd4, 3'd5, 3'd0}},
      '{1'b1, '{3'd0, 3'd1, 3'd4, 3'd3}}, '{1'b1, '{3'd0, 3'd3, 3'd5, 3'd2}},
      '{1'b1, '{3'd1, 3'd2, 3'd5, 3'd4}},
      // pyramid
      '{1'b0, '{3'd0, 3'd1, 3'd4, 3'd0}}, '{1'b0, '{3'd1, 3'd2, 3'd4, 3'd0}},
      '{1'b0, '{3'd2, 3'd3, 3'd4, 3'd0}}, '{1'b0, '{3'd3, 3'd0, 3'd4, 3'd0}},
      '{1'b1, '{3'd0, 3'd3, 3'd2, 3'd1}},
      // boundary triangle and quad
      '{1'b0, '{3'd0, 3'd1, 3'd2, 3'd0}}, '{1'b1, '{3'd0, 3'd1, 3'd2, 3'd3}}
   };

   function automatic kind_type kind_decode(input logic [3:0] op, input logic tagged_sid);
      kind_type k;
      unique case (op)
         OP_LINE, OP_POINT: k = KIND_NONE;
         OP_TRI:            k = tagged_sid ? KIND_TRI : KIND_NONE;
         OP_QUAD:           k = tagged_sid ? KIND_QUAD : KIND_NONE;
         OP_TET:            k = KIND_TET;
         OP_HEX:            k = KIND_HEX;
         OP_PRISM:          k = KIND_PRISM;
         OP_PYRAMID:        k = KIND_PYR;
         default:           k = KIND_BAD;
      endcase
      return k;
   endfunction

   // first table row of each kind
   function automatic logic [RowWidth-1:0] kind_first(input kind_type k);
      logic [RowWidth-1:0] f;
      unique case (k)
         KIND_TET:   f = RowWidth'(0);
         KIND_HEX:   f = RowWidth'(4);
         KIND_PRISM: f = RowWidth'(10);
         KIND_PYR:   f = RowWidth'(15);
         KIND_TRI:   f = RowWidth'(20);
         KIND_QUAD:  f = RowWidth'(21);
         default:    f = '0;
      endcase
      return f;
   endfunction

   // index of the final face of each kind
   function automatic logic [IdxWidth-1:0] kind_last(input kind_type k);
      logic [IdxWidth-1:0] n;
      unique case (k)
         KIND_TET:   n = IdxWidth'(3);
         KIND_HEX:   n = IdxWidth'(5);
         KIND_PRISM: n = IdxWidth'(4);
         KIND_PYR:   n = IdxWidth'(4);
         default:    n = '0;
      endcase
      return n;
   endfunction

   // Canonical order from the pairwise greater-than matrix gt[i][j] = v[i] > v[j].
   // Triangle: three compare-swaps. Quad: first least leads, reversed unless
   // the second corner is below the fourth.
   function automatic canon_type canon_face(input logic quad, input logic [3:0][3:0] gt);
      canon_type   c;
      logic [1:0]  p0;
      logic [1:0]  p1;
      logic [1:0]  p2;
      logic [1:0]  t;
      logic [1:0]  lead;
      logic [1:0]  r1;
      logic [1:0]  r3;
      c.left = 1'b1;
      c.sel  = '0;
      p0 = 2'd0;
      p1 = 2'd1;
      p2 = 2'd2;
      lead = 2'd0;
      if (!quad) begin
         if (gt[p0][p1]) begin
            t = p0; p0 = p1; p1 = t; c.left = ~c.left;
         end
         if (gt[p0][p2]) begin
            t = p0; p0 = p2; p2 = t; c.left = ~c.left;
         end
         if (gt[p1][p2]) begin
            t = p1; p1 = p2; p2 = t; c.left = ~c.left;
         end
         c.sel = '{p0, p1, p2, 2'd0};
      end else begin
         for (int j = 1; j < 4; j++) begin
            if (gt[lead][j]) lead = 2'(j);
         end
         r1 = lead + 2'd1;
         r3 = lead + 2'd3;
         if (gt[r3][r1]) begin
            c.sel = '{lead, r1, lead + 2'd2, r3};
         end else begin
            c.sel  = '{lead, r3, lead + 2'd2, r1};
            c.left = 1'b0;
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/mesh_element_face_extractor_unit.sv
// Top level of the mesh element face extractor: element register, face
// sequencer, canonical reordering and result register. Uses mefe_pkg.
//
// Each accepted element is held in an element register and gives one face per
// cycle into the result register while that register can take it: a
// tetrahedron gives 4 faces, a hexahedron 6, a prism or pyramid 5, a tagged
// boundary triangle or quad and an unsupported type 1. Lines, points and
// untagged boundary elements are accepted and give nothing. The next element is
// accepted in the same cycle as the last face of the current one, so throughput
// is set by the face count per element. A face moves into the result register
// when that register is empty or its item is being taken, so rsp_stall on a
// full result register holds the faces back. req_stall follows rsp_stall
// combinationally only on the cycle of an element's last face.
// Volume faces carry a cell number starting at 1 that advances per volume
// element and wraps within 31 bits.
module mesh_element_face_extractor_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mefe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mefe_pkg::rsp_type rsp_data
);
   import mefe_pkg::*;

   // element register
   logic                         elem_valid_ff, elem_valid_in;
   kind_type                     kind_ff, kind_in;
   logic [NodeWidth-1:0]         nodes_ff [NumNodes];
   logic [NodeWidth-1:0]         nodes_in [NumNodes];
   logic signed [OwnerWidth-1:0] owner_ff, owner_in;
   logic [IdxWidth-1:0]          face_idx_ff, face_idx_in;
   logic [NodeWidth-1:0]         next_cell_ff, next_cell_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   // control
   logic                         rsp_take;
   logic                         issue;
   logic                         elem_last;
   logic                         req_accept;
   logic                         load;
   logic                         is_volume;
   kind_type                     kind_dec;
   logic [NodeWidth-1:0]         raw_nodes [NumNodes];

   // face datapath
   face_row_type                 row;
   logic [RowWidth-1:0]          row_idx;
   logic [NodeWidth-1:0]         v [4];
   logic [3:0][3:0]              gt;
   canon_type                    canon;

   assign raw_nodes = '{req_data.node_a, req_data.node_b, req_data.node_c, req_data.node_d,
                        req_data.node_e, req_data.node_f, req_data.node_g, req_data.node_h};

   // handshake control
   assign kind_dec   = kind_decode(req_data.opcode, req_data.surface_id != '0);
   assign is_volume  = (kind_dec == KIND_TET) || (kind_dec == KIND_HEX) ||
                       (kind_dec == KIND_PRISM) || (kind_dec == KIND_PYR);
   assign rsp_take   = !rsp_valid_ff || !rsp_stall;
   assign issue      = elem_valid_ff && rsp_take;
   assign elem_last  = (face_idx_ff == kind_last(kind_ff));
   assign req_stall  = elem_valid_ff && !(issue && elem_last);
   assign req_accept = req_valid && !req_stall;
   assign load       = req_accept && (kind_dec != KIND_NONE);

   // element register next state
   always_comb begin
      elem_valid_in = elem_valid_ff;
      kind_in       = kind_ff;
      nodes_in      = nodes_ff;
      owner_in      = owner_ff;
      face_idx_in   = face_idx_ff;
      next_cell_in  = next_cell_ff;
      if (issue) begin
         face_idx_in = face_idx_ff + IdxWidth'(1);
         if (elem_last) elem_valid_in = 1'b0;
      end
      if (load) begin
         elem_valid_in = 1'b1;
         kind_in       = kind_dec;
         face_idx_in   = '0;
         // one-based to zero-based, wrapping within the node width
         for (int i = 0; i < NumNodes; i++) begin
            nodes_in[i] = raw_nodes[i] - NodeWidth'(1);
         end
         if (is_volume) begin
            owner_in     = OwnerWidth'(next_cell_ff);
            next_cell_in = next_cell_ff + NodeWidth'(1);
         end else if (kind_dec == KIND_BAD) begin
            owner_in = '0;
         end else begin
            owner_in = -$signed(OwnerWidth'(req_data.surface_id));
         end
      end
   end

   // pick the face's corners from the held nodes
   assign row_idx = kind_first(kind_ff) + RowWidth'(face_idx_ff);
   assign row     = FACE_ROWS[row_idx];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         v[j] = nodes_ff[row.pick[j]];
      end
   end

   // pairwise compares, all in parallel
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            gt[i][j] = (i != j) && (v[i] > v[j]);
         end
      end
   end

   assign canon = canon_face(row.quad, gt);

   // result assembly
   always_comb begin
      rsp_data_in = '0;
      if (kind_ff == KIND_BAD) begin
         rsp_data_in.bad_type  = 1'b1;
         rsp_data_in.last_face = 1'b1;
      end else begin
         rsp_data_in.is_quad     = row.quad;
         rsp_data_in.corner_a    = v[canon.sel[0]];
         rsp_data_in.corner_b    = v[canon.sel[1]];
         rsp_data_in.corner_c    = v[canon.sel[2]];
         rsp_data_in.corner_d    = row.quad ? v[canon.sel[3]] : '0;
         rsp_data_in.owner_cell  = owner_ff;
         rsp_data_in.orient_left = canon.left;
         rsp_data_in.last_face   = elem_last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) rsp_valid_in = issue;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         face_idx_ff   <= '0;
         kind_ff       <= KIND_NONE;
         next_cell_ff  <= NodeWidth'(1);
      end else begin
         elem_valid_ff <= elem_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         face_idx_ff   <= face_idx_in;
         kind_ff       <= kind_in;
         next_cell_ff  <= next_cell_in;
      end
      nodes_ff <= nodes_in;
      owner_ff <= owner_in;
      if (issue) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      elem_valid_ff |-> (face_idx_ff <= kind_last(kind_ff)))
      else $error("face index past the element's last face");

   a_tri_no_fourth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.is_quad) |-> (rsp_data_ff.corner_d == '0))
      else $error("triangle face carries a fourth corner");

   a_least_leads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.bad_type) |->
         ((rsp_data_ff.corner_a <= rsp_data_ff.corner_b) &&
          (rsp_data_ff.corner_a <= rsp_data_ff.corner_c)))
      else $error("face does not start at its least corner");

   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bad_type) |->
         (rsp_data_ff.last_face && (rsp_data_ff.owner_cell == '0)))
      else $error("unsupported type result malformed");

endmodule
